/* rtl/coospmv_pkg.sv */
package coospmv_pkg;

	// Fixed field widths
	localparam int VALUE_W    = 32;
	localparam int NUM_ROWS_W = 11;
	localparam int CFG_IDX_W  = 2;

	// Item operation codes
	typedef enum logic [1:0] {
		OP_LOAD_X = 2'd0,
		OP_LOAD_Y = 2'd1,
		OP_ENTRY  = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BETA      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TRANSPOSE = 2'd3;

	// Register reset values
	localparam logic [NUM_ROWS_W-1:0]    NUM_ROWS_RST = 11'd1024;
	localparam logic signed [VALUE_W-1:0] ALPHA_RST   = 32'sd65536;
	localparam logic signed [VALUE_W-1:0] BETA_RST    = 32'sd0;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_STEP1,
		ST_STEP2
	} state_t;

endpackage

/* rtl/coo_sparse_matrix_vector_multiply.sv */
// Sparse matrix-vector multiply over coordinate-format entries, Q16.16.
// Computes acc = alpha*A*x + beta*y (or alpha*x*A + beta*y with transpose set).
// Command channel: a transaction is taken at a clock edge with start high and
// busy low; operation selects load x, load y, matrix entry or read result.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 num_rows,
// 1 alpha, 2 beta, 3 transpose) at once; write only while busy is low.
// Result channel: a read returns one transaction, valid for the single cycle
// that done is high, in the cycle after the read is taken. The receiver cannot
// stall; results must be taken as they appear.
// Sequence: an x load is written as it is taken and leaves busy low; a read
// (one out of range returns zero) and a y load pass through ST_STEP1, and a
// matrix entry through ST_STEP1 and ST_STEP2 (a y load or matrix entry whose
// index is out of range stays idle). The x and accumulator memories each have
// one registered read port, and a matrix entry passes the shared multiplier
// twice (alpha*value, then times x). Out-of-range indices set the sticky
// index_error; other such transactions are dropped. Reset clears the registers
// to num_rows 1024, alpha 1.0, beta 0, transpose 0 and clears index_error;
// vector memories are not cleared and must be loaded before they are read.
module coo_sparse_matrix_vector_multiply #(
	parameter int VECTOR_DEPTH = 1024
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        start,
	output logic                                        busy,
	input  coospmv_pkg::op_t                            operation,
	input  logic [$clog2(VECTOR_DEPTH)-1:0]             position,
	input  logic [$clog2(VECTOR_DEPTH)-1:0]             column,
	input  logic signed [coospmv_pkg::VALUE_W-1:0]      value,
	input  logic                                        cfg_we,
	input  logic [coospmv_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  logic [coospmv_pkg::VALUE_W-1:0]             cfg_data,
	output logic                                        done,
	output logic signed [coospmv_pkg::VALUE_W-1:0]      result_value,
	output logic [$clog2(VECTOR_DEPTH)-1:0]             result_position,
	output logic                                        index_error
);

	import coospmv_pkg::*;

	localparam int IDX_W = $clog2(VECTOR_DEPTH);
	localparam int CNT_W = $clog2(VECTOR_DEPTH + 1);
	localparam int CMP_W = (CNT_W > NUM_ROWS_W) ? CNT_W : NUM_ROWS_W;
	localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(VECTOR_DEPTH);

	// Configuration registers
	logic [NUM_ROWS_W-1:0]        num_rows_q;
	logic signed [VALUE_W-1:0]    alpha_q;
	logic signed [VALUE_W-1:0]    beta_q;
	logic                         transpose_q;

	// Sequencer and item registers
	state_t                       state_q, state_d;
	op_t                          op_q;
	logic [IDX_W-1:0]             pos_q;
	logic [IDX_W-1:0]             dst_q;
	logic                         ok_q;
	logic                         err_q;

	logic                         accept;
	logic [CMP_W-1:0]             rows;
	logic [IDX_W-1:0]             dst;
	logic [IDX_W-1:0]             src;
	logic                         ok;

	logic signed [VALUE_W-1:0]    mul_a, mul_b, mul_q;
	logic [VALUE_W-1:0]           x_rd, acc_rd;
	logic                         x_we;
	logic                         acc_we;
	logic [IDX_W-1:0]             acc_waddr;
	logic [VALUE_W-1:0]           acc_wdata;
	logic signed [VALUE_W:0]      sum;
	logic [VALUE_W-1:0]           sum_sat;

	assign accept = start && !busy;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q  <= NUM_ROWS_RST;
			alpha_q     <= ALPHA_RST;
			beta_q      <= BETA_RST;
			transpose_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_NUM_ROWS:  num_rows_q  <= cfg_data[NUM_ROWS_W-1:0];
				CFG_ALPHA:     alpha_q     <= cfg_data;
				CFG_BETA:      beta_q      <= cfg_data;
				CFG_TRANSPOSE: transpose_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Index range check on the incoming transaction
	always_comb begin
		rows = (CMP_W'(num_rows_q) > DEPTH_C) ? DEPTH_C : CMP_W'(num_rows_q);
		dst  = transpose_q ? column : position;
		src  = transpose_q ? position : column;
		unique case (operation)
			OP_LOAD_X: ok = CMP_W'(position) < DEPTH_C;
			OP_ENTRY:  ok = (CMP_W'(dst) < rows) && (CMP_W'(src) < DEPTH_C);
			default:   ok = CMP_W'(position) < rows;
		endcase
	end

	// Latch the transaction and the sticky error
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			err_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && !ok) begin
				err_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= operation;
			pos_q <= position;
			dst_q <= dst;
			ok_q  <= ok;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (operation)
						OP_LOAD_X: state_d = ST_IDLE;
						OP_READ:   state_d = ST_STEP1;
						default:   state_d = ok ? ST_STEP1 : ST_IDLE;
					endcase
				end
			end
			ST_STEP1: state_d = (op_q == OP_ENTRY) ? ST_STEP2 : ST_IDLE;
			ST_STEP2: state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		busy   = 1'b1;
		done   = 1'b0;
		acc_we = 1'b0;
		unique case (state_q)
			ST_IDLE:  busy = 1'b0;
			ST_STEP1: begin
				done   = (op_q == OP_READ);
				acc_we = (op_q == OP_LOAD_Y);
			end
			ST_STEP2: acc_we = 1'b1;
			default:  busy = 1'b1;
		endcase
	end

	// Multiplier operands: scale by alpha or beta first, then by x
	always_comb begin
		if (state_q == ST_STEP1) begin
			mul_a = mul_q;
			mul_b = x_rd;
		end else begin
			mul_a = (operation == OP_LOAD_Y) ? beta_q : alpha_q;
			mul_b = value;
		end
	end

	coospmv_qmul u_qmul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.q   (mul_q)
	);

	// Saturating accumulate
	always_comb begin
		sum = {acc_rd[VALUE_W-1], acc_rd} + {mul_q[VALUE_W-1], mul_q};
		if (sum[VALUE_W] != sum[VALUE_W-1]) begin
			sum_sat = sum[VALUE_W] ? {1'b1, {(VALUE_W-1){1'b0}}}
			                       : {1'b0, {(VALUE_W-1){1'b1}}};
		end else begin
			sum_sat = sum[VALUE_W-1:0];
		end
	end

	// Accumulator write-back
	assign x_we      = accept && (operation == OP_LOAD_X) && ok;
	assign acc_waddr = (state_q == ST_STEP2) ? dst_q : pos_q;
	assign acc_wdata = (state_q == ST_STEP2) ? sum_sat : mul_q;

	coospmv_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (VECTOR_DEPTH)
	) u_x_ram (
		.clk   (clk),
		.we    (x_we),
		.waddr (position),
		.wdata (value),
		.re    (accept),
		.raddr (src),
		.rdata (x_rd)
	);

	coospmv_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (VECTOR_DEPTH)
	) u_acc_ram (
		.clk   (clk),
		.we    (acc_we),
		.waddr (acc_waddr),
		.wdata (acc_wdata),
		.re    (accept),
		.raddr ((operation == OP_ENTRY) ? dst : position),
		.rdata (acc_rd)
	);

	// Result fields
	assign result_value    = ok_q ? acc_rd : '0;
	assign result_position = pos_q;
	assign index_error     = err_q;

`ifndef SYNTHESIS
	a_done_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept && operation == OP_READ))
		else $error("result without a read transaction");

	a_load_x_single: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && operation == OP_LOAD_X) |=> !busy)
		else $error("x load held the block busy");

	a_entry_length: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && operation == OP_ENTRY && ok) |=> busy ##1 busy ##1 !busy)
		else $error("matrix entry did not take three cycles");

	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		err_q |=> err_q)
		else $error("index error flag cleared");

	a_bad_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !ok_q) |-> (result_value == '0 && index_error))
		else $error("out-of-range read returned data");
`endif

endmodule

/* rtl/coospmv_ram.sv */
module coospmv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port, held between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/coospmv_qmul.sv */
module coospmv_qmul (
	input  logic                                    clk,
	input  logic signed [coospmv_pkg::VALUE_W-1:0] a,
	input  logic signed [coospmv_pkg::VALUE_W-1:0] b,
	output logic signed [coospmv_pkg::VALUE_W-1:0] q
);

	import coospmv_pkg::*;

	localparam int PROD_W = 2 * VALUE_W;

	logic signed [PROD_W-1:0] prod_s1;
	logic signed [PROD_W-1:0] shifted;

	// Register the full product
	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
	end

	// Drop 16 fraction bits (floor), then saturate to the value range
	always_comb begin
		shifted = prod_s1 >>> 16;
		if (shifted[PROD_W-1:VALUE_W-1] == '0 || shifted[PROD_W-1:VALUE_W-1] == '1) begin
			q = shifted[VALUE_W-1:0];
		end else if (shifted[PROD_W-1]) begin
			q = {1'b1, {(VALUE_W-1){1'b0}}};
		end else begin
			q = {1'b0, {(VALUE_W-1){1'b1}}};
		end
	end

endmodule
